FILE: hw/rtl/ole_pkg.sv
// ----------------------------------------------------------------------------
// ole_pkg
// Shared types and constants for the ordered list engine.
// ----------------------------------------------------------------------------
package ole_pkg;

  localparam int DATA_W  = 32;
  localparam int COUNT_W = 5;

  typedef enum logic [1:0] {
    CMD_INS_FRONT = 2'd0,
    CMD_INS_BACK  = 2'd1,
    CMD_REMOVE    = 2'd2,
    CMD_READOUT   = 2'd3
  } cmd_e_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_FULL      = 2'd1,
    STS_EMPTY     = 2'd2,
    STS_NOT_FOUND = 2'd3
  } status_e_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT,
    ST_READ,
    ST_RESP
  } state_e_t;

  typedef struct packed {
    cmd_e_t                    command;
    logic signed [DATA_W-1:0]  value;
  } in_t;

  typedef struct packed {
    status_e_t                 status;
    logic signed [DATA_W-1:0]  element;
    logic                      last;
    logic [COUNT_W-1:0]        count;
  } out_t;

endpackage

FILE: hw/rtl/ole_mem.sv
// ----------------------------------------------------------------------------
// ole_mem
// Entry storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ole_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [ole_pkg::DATA_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [ole_pkg::DATA_W-1:0] rdata
);
  import ole_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/ole_outq.sv
// ----------------------------------------------------------------------------
// ole_outq
// Two-entry result queue in front of the output channel.
// ----------------------------------------------------------------------------
module ole_outq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ole_pkg::out_t push_data,
  output logic          out_valid,
  input  logic          out_ready,
  output ole_pkg::out_t out_data,
  output logic [1:0]    fill
);
  import ole_pkg::*;

  out_t       ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = ent_r[rd_ptr_r];
  assign fill      = cnt_r;
  assign pop       = out_valid & out_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: hw/rtl/ordered_list_engine_core.sv
// The list lives in a DEPTH-entry memory used as a ring: a head pointer and a
// count give the logical order, so front and back inserts write one entry.
// Remove reads the list front to back one entry a cycle through the single
// memory read port, then moves every later entry down one place at one entry
// a cycle. Read-out reads one entry a cycle into a two-entry result queue
// when the output side keeps up, and stalls while that queue has no room.
// One request is worked at a time. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
// ordered_list_engine_core
// Ordered list of signed words with insert, remove and read-out requests.
// ----------------------------------------------------------------------------
module ordered_list_engine_core #(
  parameter int DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  ole_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output ole_pkg::out_t out_data
);
  import ole_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  state_e_t                 state_r, state_nxt;
  logic [AW-1:0]            head_r, head_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic signed [DATA_W-1:0] val_r, val_nxt;
  logic [CW-1:0]            idx_r, idx_nxt;
  logic [AW-1:0]            tag_r, tag_nxt;
  logic                     pend_r, pend_nxt;
  status_e_t                status_r, status_nxt;

  logic                     mem_we, mem_re;
  logic [AW-1:0]            mem_waddr, mem_raddr;
  logic [DATA_W-1:0]        mem_wdata, mem_rdata;

  logic                     push;
  out_t                     push_data;
  logic [1:0]               q_fill;
  logic                     pop;
  logic [2:0]               occ;
  logic                     credit_ok;
  logic                     accept;
  logic                     full;
  logic                     hit;
  logic                     last_tag;
  logic                     idx_more;
  logic [AW-1:0]            head_m1;

  // ring position of logical index k
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [AW-1:0] k);
    logic [AW:0] s;
    s = {1'b0, head} + {1'b0, k};
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  ole_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ole_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .fill      (q_fill)
  );

  assign pop       = out_valid & out_ready;
  // slots taken in the next cycle, counting a read still in flight
  assign occ       = 3'(q_fill) + 3'(pend_r) - 3'(pop);
  assign credit_ok = (occ <= 3'd1);
  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid & in_ready;
  assign full      = (count_r == CW'(DEPTH));
  assign hit       = pend_r && (mem_rdata == val_r);
  assign last_tag  = (CW'(tag_r) == count_r - CW'(1));
  assign idx_more  = (idx_r < count_r);
  assign head_m1   = (head_r == '0) ? AW'(DEPTH - 1) : head_r - 1'b1;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_data.command)
            CMD_REMOVE:  state_nxt = (count_r == '0) ? ST_RESP : ST_SEARCH;
            CMD_READOUT: state_nxt = (count_r == '0) ? ST_RESP : ST_READ;
            default:     state_nxt = ST_RESP;
          endcase
        end
      end
      ST_SEARCH: begin
        if (hit) begin
          state_nxt = ST_SHIFT;
        end else if (pend_r && last_tag) begin
          state_nxt = ST_RESP;
        end
      end
      ST_SHIFT: begin
        if (!idx_more && !pend_r) begin
          state_nxt = ST_RESP;
        end
      end
      ST_READ: begin
        if (!idx_more && !pend_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RESP: begin
        if (credit_ok) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    val_nxt    = val_r;
    idx_nxt    = idx_r;
    tag_nxt    = tag_r;
    pend_nxt   = 1'b0;
    status_nxt = status_r;
    mem_we     = 1'b0;
    mem_waddr  = phys(head_r, tag_r - 1'b1);
    mem_wdata  = mem_rdata;
    mem_re     = 1'b0;
    mem_raddr  = phys(head_r, idx_r[AW-1:0]);
    push       = 1'b0;
    push_data  = '{status: status_r, element: '0, last: 1'b1,
                   count: COUNT_W'(count_r)};
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          val_nxt    = in_data.value;
          idx_nxt    = '0;
          status_nxt = STS_OK;
          case (in_data.command)
            CMD_INS_FRONT: begin
              if (full) begin
                status_nxt = STS_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = head_m1;
                mem_wdata = in_data.value;
                head_nxt  = head_m1;
                count_nxt = count_r + 1'b1;
              end
            end
            CMD_INS_BACK: begin
              if (full) begin
                status_nxt = STS_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = phys(head_r, count_r[AW-1:0]);
                mem_wdata = in_data.value;
                count_nxt = count_r + 1'b1;
              end
            end
            default: begin
              if (count_r == '0) begin
                status_nxt = STS_EMPTY;
              end
            end
          endcase
        end
      end
      ST_SEARCH: begin
        if (hit) begin
          // start moving entries after the match down one place
          idx_nxt = CW'(tag_r) + 1'b1;
        end else begin
          if (idx_more) begin
            mem_re   = 1'b1;
            idx_nxt  = idx_r + 1'b1;
            tag_nxt  = idx_r[AW-1:0];
            pend_nxt = 1'b1;
          end
          if (pend_r && last_tag) begin
            status_nxt = STS_NOT_FOUND;
          end
        end
      end
      ST_SHIFT: begin
        if (pend_r) begin
          mem_we = 1'b1;
        end
        if (idx_more) begin
          mem_re   = 1'b1;
          idx_nxt  = idx_r + 1'b1;
          tag_nxt  = idx_r[AW-1:0];
          pend_nxt = 1'b1;
        end else if (!pend_r) begin
          count_nxt  = count_r - 1'b1;
          status_nxt = STS_OK;
        end
      end
      ST_READ: begin
        if (idx_more && credit_ok) begin
          mem_re   = 1'b1;
          idx_nxt  = idx_r + 1'b1;
          tag_nxt  = idx_r[AW-1:0];
          pend_nxt = 1'b1;
        end
        if (pend_r) begin
          push      = 1'b1;
          push_data = '{status: STS_OK, element: signed'(mem_rdata), last: last_tag,
                        count: COUNT_W'(count_r)};
        end
      end
      ST_RESP: begin
        push = credit_ok;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      head_r   <= '0;
      count_r  <= '0;
      idx_r    <= '0;
      pend_r   <= 1'b0;
      status_r <= STS_OK;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      count_r  <= count_nxt;
      idx_r    <= idx_nxt;
      pend_r   <= pend_nxt;
      status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    tag_r <= tag_nxt;
  end

endmodule
